FILE: rtl/core/rti_pkg.sv
package rti_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned ScaleResetValue   = 65536;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgPointsInUse  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLengthScale  = 1'b1;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture query item, start norm
    logic sqrt_step;  // one square-root step
    logic scale_lo;   // partial product, low half of scale
    logic scale_hi;   // partial product, high half of scale
    logic ends_rd;    // issue read of last entry
    logic ends_chk;   // decide end cases
    logic bs_rd;      // issue binary-search read
    logic bs_upd;     // update search bounds
    logic pair_rd0;   // read lower entry
    logic pair_rd1;   // read upper entry
    logic pair_chk;   // check bounds of the pair
    logic div_step;   // one fraction bit
    logic mul;        // scale delta by fraction
    logic fin;        // form result
  } rti_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic bs_done;
    logic div_done;
    logic early;      // result already settled
  } rti_sts_t;

endpackage

FILE: rtl/core/rti_ram.sv
module rti_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/rti_datapath.sv
module rti_datapath
  import rti_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic                          clk,
  input  logic                          tbl_we,
  input  logic [$clog2(TableDepth)-1:0] tbl_waddr,
  input  logic [47:0]                   tbl_wradius,
  input  logic [31:0]                   tbl_wdensity,
  input  logic [31:0]                   coord_x,
  input  logic [31:0]                   coord_y,
  input  logic [31:0]                   coord_z,
  input  logic [8:0]                    points_in_use,
  input  logic [39:0]                   length_scale,
  input  rti_pkg::rti_cmd_t             cmd,
  output rti_pkg::rti_sts_t             sts,
  output logic [31:0]                   density
);
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = AddrW + 1;

  logic [CntW-1:0] n_eff;
  always_comb begin
    if (32'(points_in_use) > TableDepth) begin
      n_eff = CntW'(TableDepth);
    end else begin
      n_eff = CntW'(points_in_use);
    end
  end

  logic [AddrW-1:0] raddr;
  logic [47:0]      rd_radius;
  logic [31:0]      rd_density;

  rti_ram #(.Width(48), .Depth(TableDepth)) u_radius_ram (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wradius),
    .raddr(raddr), .rdata(rd_radius)
  );
  rti_ram #(.Width(32), .Depth(TableDepth)) u_density_ram (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdensity),
    .raddr(raddr), .rdata(rd_density)
  );

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // squared norm accumulates over three sqrt-phase steps, one per axis, before the root bits
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [4:0]  sq_cnt_r, sq_cnt_nxt;
  logic [1:0]  acc_cnt_r, acc_cnt_nxt;
  logic [31:0] ax_r, ay_r, az_r;
  logic [47:0] radius_r, radius_nxt;
  logic [71:0] prod_r, prod_nxt;
  logic [CntW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [47:0] x0_r, r_last_r;
  logic [31:0] y0_r, y1_r, d_last_r;
  logic [47:0] num_r, num_nxt, den_r;
  logic [31:0] t_r, t_nxt;
  logic [5:0]  div_cnt_r, div_cnt_nxt;
  logic [31:0] res_r, res_nxt;
  logic        early_r, early_nxt;
  logic [31:0] dmul_r;

  logic [63:0] sq_term;
  logic [CntW-1:0] mid;
  logic [CntW-1:0] i1;
  logic [48:0] num_sh;
  logic [31:0] dy;
  logic        up;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  always_comb begin
    i1 = lo_r;
    if (i1 < CntW'(1)) i1 = CntW'(1);
    if (i1 > n_eff - CntW'(1)) i1 = n_eff - CntW'(1);
  end

  always_comb begin
    unique case (acc_cnt_r)
      2'd0:    sq_term = 64'(ax_r) * 64'(ax_r);
      2'd1:    sq_term = 64'(ay_r) * 64'(ay_r);
      default: sq_term = 64'(az_r) * 64'(az_r);
    endcase
  end

  // restoring square root, two radicand bits per step, one root bit a cycle
  assign num_sh = {num_r, 1'b0};
  assign up     = y1_r >= y0_r;
  assign dy     = up ? (y1_r - y0_r) : (y0_r - y1_r);

  logic [65:0] sq_rem_sh;
  logic [33:0] sq_try;
  logic [63:0] sq_src_r;

  always_comb begin
    raddr       = '0;
    rem_nxt     = rem_r;
    root_nxt    = root_r;
    sq_cnt_nxt  = sq_cnt_r;
    acc_cnt_nxt = acc_cnt_r;
    radius_nxt  = radius_r;
    prod_nxt    = prod_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    num_nxt     = num_r;
    t_nxt       = t_r;
    div_cnt_nxt = div_cnt_r;
    res_nxt     = res_r;
    early_nxt   = early_r;
    sq_rem_sh   = '0;
    sq_try      = '0;

    if (cmd.load) begin
      rem_nxt     = '0;
      root_nxt    = '0;
      sq_cnt_nxt  = '0;
      acc_cnt_nxt = '0;
      early_nxt   = 1'b0;
    end
    if (cmd.sqrt_step) begin
      if (acc_cnt_r != 2'd3) begin
        // accumulate squared norm first
        acc_cnt_nxt = acc_cnt_r + 2'd1;
      end else begin
        sq_rem_sh = {rem_r[63:0], sq_src_r[63:62]};
        sq_try    = {root_r, 2'b01};
        if (sq_rem_sh >= 66'(sq_try)) begin
          rem_nxt  = 64'(sq_rem_sh - 66'(sq_try));
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt  = 64'(sq_rem_sh);
          root_nxt = {root_r[30:0], 1'b0};
        end
        sq_cnt_nxt = sq_cnt_r + 5'd1;
      end
    end
    if (cmd.scale_lo) begin
      prod_nxt = 72'((64'(root_r) * 64'(length_scale[15:0])) >> 16);
    end
    if (cmd.scale_hi) begin
      prod_nxt = prod_r + 72'(64'(root_r) * 64'(length_scale[39:16]));
    end
    if (cmd.ends_rd) begin
      radius_nxt = (prod_r > 72'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : prod_r[47:0];
      raddr      = AddrW'(n_eff - CntW'(1));
    end
    if (cmd.ends_chk) begin
      lo_nxt = '0;
      hi_nxt = n_eff;
      raddr  = '0;
      if (n_eff == '0) begin
        early_nxt = 1'b1;
        res_nxt   = 32'd0;
      end else if (n_eff == CntW'(1) || radius_r <= rd_radius) begin
        early_nxt = 1'b1;
        res_nxt   = rd_density;
      end else if (radius_r >= r_last_r) begin
        early_nxt = 1'b1;
        res_nxt   = d_last_r;
      end
    end
    if (cmd.bs_rd) begin
      raddr = mid[AddrW-1:0];
    end
    if (cmd.bs_upd) begin
      if (rd_radius < radius_r) lo_nxt = mid + CntW'(1);
      else                      hi_nxt = mid;
    end
    if (cmd.pair_rd0) begin
      raddr = AddrW'(i1 - CntW'(1));
    end
    if (cmd.pair_rd1) begin
      raddr = i1[AddrW-1:0];
    end
    if (cmd.pair_chk) begin
      num_nxt     = radius_r - x0_r;
      t_nxt       = '0;
      div_cnt_nxt = '0;
      if (radius_r <= x0_r) begin
        early_nxt = 1'b1;
        res_nxt   = y0_r;
      end else if (radius_r >= rd_radius) begin
        early_nxt = 1'b1;
        res_nxt   = rd_density;
      end
    end
    if (cmd.div_step) begin
      if (num_sh >= {1'b0, den_r}) begin
        num_nxt = 48'(num_sh - {1'b0, den_r});
        t_nxt   = {t_r[30:0], 1'b1};
      end else begin
        num_nxt = num_sh[47:0];
        t_nxt   = {t_r[30:0], 1'b0};
      end
      div_cnt_nxt = div_cnt_r + 6'd1;
    end
    if (cmd.fin) begin
      res_nxt = up ? (y0_r + dmul_r) : (y0_r - dmul_r);
    end
  end

  // end checks, done in the cycle after the end read returns
  logic ends_seen_r;

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    sq_cnt_r    <= sq_cnt_nxt;
    acc_cnt_r   <= acc_cnt_nxt;
    radius_r    <= radius_nxt;
    prod_r      <= prod_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    num_r       <= num_nxt;
    t_r         <= t_nxt;
    div_cnt_r   <= div_cnt_nxt;
    res_r       <= res_nxt;
    early_r     <= early_nxt;
    ends_seen_r <= cmd.ends_rd;
    if (cmd.load) begin
      ax_r     <= mag32(coord_x);
      ay_r     <= mag32(coord_y);
      az_r     <= mag32(coord_z);
      sq_src_r <= '0;
    end else if (cmd.sqrt_step) begin
      if (acc_cnt_r != 2'd3) sq_src_r <= sq_src_r + sq_term;
      else                   sq_src_r <= {sq_src_r[61:0], 2'b00};
    end
    if (ends_seen_r) begin
      r_last_r <= rd_radius;
      d_last_r <= rd_density;
    end
    if (cmd.pair_rd1) begin
      x0_r <= rd_radius;
      y0_r <= rd_density;
    end
    if (cmd.pair_chk) begin
      y1_r  <= rd_density;
      den_r <= rd_radius - x0_r;
    end
    if (cmd.mul) begin
      dmul_r <= 32'((64'(dy) * 64'(t_r)) >> 32);
    end
  end

  assign sts.sqrt_done = (acc_cnt_r == 2'd3) && (sq_cnt_r == 5'd31) && cmd.sqrt_step;
  assign sts.bs_done   = !(lo_r < hi_r);
  assign sts.div_done  = div_cnt_r == 6'd31 && cmd.div_step;
  assign sts.early     = early_r;
  assign density       = res_r;
endmodule

FILE: rtl/core/rti_ctrl.sv
module rti_ctrl
  import rti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_cmd,
  input  logic              out_tready,
  input  rti_pkg::rti_sts_t sts,
  output rti_pkg::rti_cmd_t cmd,
  output logic              busy,
  output logic              out_tvalid,
  output logic              out_write_done,
  output logic              use_zero
);
  typedef enum logic [4:0] {
    S_IDLE, S_SQRT, S_SCLO, S_SCHI, S_ENDRD, S_ENDWT, S_ENDCHK, S_BSRD,
    S_BSUPD, S_P0, S_P1, S_PCHK, S_DIV, S_MUL, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic   wd_r;
  logic   zero_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_SQRT:   cmd.sqrt_step = 1'b1;
      S_SCLO:   cmd.scale_lo  = 1'b1;
      S_SCHI:   cmd.scale_hi  = 1'b1;
      S_ENDRD:  cmd.ends_rd   = 1'b1;
      S_ENDCHK: cmd.ends_chk  = 1'b1;
      S_BSRD:   cmd.bs_rd     = 1'b1;
      S_BSUPD:  cmd.bs_upd    = 1'b1;
      S_P0:     cmd.pair_rd0  = 1'b1;
      S_P1:     cmd.pair_rd1  = 1'b1;
      S_PCHK:   cmd.pair_chk  = 1'b1;
      S_DIV:    cmd.div_step  = 1'b1;
      S_MUL:    cmd.mul       = 1'b1;
      S_FIN:    cmd.fin       = 1'b1;
      default:  ;
    endcase
    cmd.load = in_fire && in_cmd == CmdQuery;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wd_r    <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            wd_r   <= in_cmd == CmdWrite;
            zero_r <= in_cmd == CmdWrite;
            state_r <= (in_cmd == CmdWrite) ? S_OUT : S_SQRT;
          end
        end
        S_SQRT:   if (sts.sqrt_done) state_r <= S_SCLO;
        S_SCLO:   state_r <= S_SCHI;
        S_SCHI:   state_r <= S_ENDRD;
        S_ENDRD:  state_r <= S_ENDWT;
        S_ENDWT:  state_r <= S_ENDCHK;
        S_ENDCHK: state_r <= S_BSRD;
        S_BSRD: begin
          if (sts.early) state_r <= S_OUT;
          else if (sts.bs_done) state_r <= S_P0;
          else state_r <= S_BSUPD;
        end
        S_BSUPD:  state_r <= S_BSRD;
        S_P0:     state_r <= S_P1;
        S_P1:     state_r <= S_PCHK;
        S_PCHK:   state_r <= S_DIV;
        S_DIV: begin
          if (sts.early) state_r <= S_OUT;
          else if (sts.div_done) state_r <= S_MUL;
        end
        S_MUL:    state_r <= S_FIN;
        S_FIN:    state_r <= S_OUT;
        S_OUT:    if (out_tready) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = state_r != S_IDLE;
  assign out_tvalid     = state_r == S_OUT;
  assign out_write_done = wd_r;
  assign use_zero       = zero_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.load)
    else $error("query loaded while busy");
  a_write_direct: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_cmd == CmdWrite |=> out_tvalid)
    else $error("write not acknowledged next cycle");
endmodule

FILE: rtl/core/radial_table_interpolator_core.sv
// channel | dir | tdata fields (low bit up)                                  | tuser
// in_     | in  | entry_index, entry_radius, entry_density, x, y, z (184 bits) | command
// out_    | out | density (32 bits)                                           | write_done
// cfg_    | in  | index 0 points_in_use, index 1 length_scale                 | -
// A write item offers its result in the cycle after acceptance. A query squares the three
// axes and forms 32 root bits for the norm, scales it by the low and high halves of
// length_scale, reads and checks the table ends, then runs binary-search steps (up to 9
// over 256 entries), reads the pair and forms 32 fraction bits and the product. An end
// case exits after the end checks; a clamp at the pair exits after the pair check. in_tready
// is low from acceptance until the result is taken; rst_n is synchronous; the table RAMs are not cleared.
module radial_table_interpolator_core
  import rti_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [183:0]  in_tdata,  // entry_index, entry_radius, entry_density, x, y, z
  input  logic          in_tuser,  // command
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata, // density
  output logic          out_tuser, // write_done
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [39:0]   cfg_wdata
);
  localparam int unsigned AddrW = $clog2(TableDepth);

  logic [8:0]  points_in_use_r;
  logic [39:0] length_scale_r;
  rti_cmd_t    cmd;
  rti_sts_t    sts;
  logic        busy;
  logic        in_fire;
  logic        use_zero;
  logic [31:0] density;
  logic        tbl_we;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign tbl_we    = in_fire && in_tuser == CmdWrite && (32'(in_tdata[7:0]) < TableDepth);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_in_use_r <= '0;
      length_scale_r  <= 40'(ScaleResetValue);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgPointsInUse: points_in_use_r <= cfg_wdata[8:0];
        CfgLengthScale: length_scale_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rti_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_cmd(in_tuser),
    .out_tready(out_tready), .sts(sts), .cmd(cmd), .busy(busy),
    .out_tvalid(out_tvalid), .out_write_done(out_tuser), .use_zero(use_zero)
  );

  rti_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk(clk), .tbl_we(tbl_we), .tbl_waddr(AddrW'(in_tdata[7:0])),
    .tbl_wradius(in_tdata[55:8]), .tbl_wdensity(in_tdata[87:56]),
    .coord_x(in_tdata[119:88]), .coord_y(in_tdata[151:120]),
    .coord_z(in_tdata[183:152]), .points_in_use(points_in_use_r),
    .length_scale(length_scale_r), .cmd(cmd), .sts(sts), .density(density)
  );

  assign out_tdata = use_zero ? 32'd0 : density;
endmodule
